>>> sv/bright_pixel_centroid_defines.svh
// Assertion macros shared by the bright pixel centroid RTL.
`ifndef BRIGHT_PIXEL_CENTROID_DEFINES_SVH
`define BRIGHT_PIXEL_CENTROID_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication under synchronous active-low reset.
`define BPC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bpc: same-cycle check failed");
// Next-cycle implication under synchronous active-low reset.
`define BPC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bpc: next-cycle check failed");
`else
`define BPC_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define BPC_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

>>> sv/bpc_pkg.sv
// Types, constants and helpers for the bright pixel centroid block.
package bpc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Fixed field widths of the interface.
  localparam int LEVEL_W = 8;
  localparam int SIZE_W  = 11;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CX_W    = 10;
  localparam int CY_W    = 10;
  localparam int HIT_W   = 21;

  // Internal widths follow the frame size limits.
  localparam int X_POS_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int Y_POS_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int Q_W     = (X_POS_W > Y_POS_W) ? X_POS_W : Y_POS_W;
  localparam int CNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SUM_W   = Q_W + CNT_W - 1;
  localparam int LIM_W   = (Q_W + 1 > SIZE_W) ? Q_W + 1 : SIZE_W;
  localparam int STEP_W  = (Q_W > 1) ? $clog2(Q_W) : 1;

  localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = LEVEL_W'(251);
  localparam logic [SIZE_W-1:0]  WIDTH_RESET     = SIZE_W'(640);
  localparam logic [SIZE_W-1:0]  HEIGHT_RESET    = SIZE_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } bpc_reg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] pixel_level;
    logic               frame_start;
  } bpc_pix_t;

  typedef struct packed {
    logic [CX_W-1:0]  centroid_x;
    logic [CY_W-1:0]  centroid_y;
    logic [HIT_W-1:0] hit_count;
    logic             found;
  } bpc_res_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic last_x;
    logic load_out;
  } bpc_cmd_t;

  typedef struct packed {
    logic frame_end;
  } bpc_sts_t;

  // Zero counts as one, anything above the maximum saturates.
  function automatic logic [LIM_W-1:0] limit_size(logic [SIZE_W-1:0] v,
                                                  logic [LIM_W-1:0] maxv);
    logic [LIM_W-1:0] vv;
    vv = LIM_W'(v);
    if (vv == '0) return LIM_W'(1);
    if (vv > maxv) return maxv;
    return vv;
  endfunction

endpackage

>>> sv/bpc_ctrl.sv
// Sequencer for pixel accumulation, serial divisions and result handoff.
module bpc_ctrl
  import bpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  bpc_sts_t sts,
  output bpc_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIV_X,
    ST_DIV_Y,
    ST_OUT
  } state_t;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(Q_W - 1);

  state_t            state_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  logic              last_step;

  assign in_stall  = (state_r != ST_ACCUM);
  assign out_valid = out_valid_r;
  assign last_step = (step_r == STEP_LAST);

  always_comb begin
    cmd.accept   = in_valid && (state_r == ST_ACCUM);
    cmd.step     = (state_r == ST_DIV_X) || (state_r == ST_DIV_Y);
    cmd.last_x   = (state_r == ST_DIV_X) && last_step;
    cmd.load_out = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_ACCUM: begin
          if (cmd.accept && sts.frame_end) begin
            state_r <= ST_DIV_X;
            step_r  <= '0;
          end
        end
        ST_DIV_X: begin
          if (last_step) begin
            state_r <= ST_DIV_Y;
            step_r  <= '0;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        ST_DIV_Y: begin
          if (last_step) begin
            state_r <= ST_OUT;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        ST_OUT: begin
          if (cmd.load_out) state_r <= ST_ACCUM;
        end
        default: state_r <= ST_ACCUM;
      endcase

      // Hold the result until the far side takes it.
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

endmodule

>>> sv/bpc_datapath.sv
// Position tracking, bright pixel sums, shared restoring divider and result register.
module bpc_datapath
  import bpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  bpc_pix_t             in_data,
  output bpc_res_t             out_data,
  input  bpc_cmd_t             cmd,
  output bpc_sts_t             sts
);

  logic [LEVEL_W-1:0] thr_r;
  logic [SIZE_W-1:0]  width_r;
  logic [SIZE_W-1:0]  height_r;

  logic [X_POS_W-1:0] col_r;
  logic [Y_POS_W-1:0] row_r;
  logic [SUM_W-1:0]   xsum_r;
  logic [SUM_W-1:0]   ysum_r;
  logic [CNT_W-1:0]   cnt_r;

  // Frame snapshot and divider state.
  logic [SUM_W-1:0]   dvy_r;
  logic [CNT_W-1:0]   dcnt_r;
  logic [CNT_W-1:0]   rem_r;
  logic [Q_W-1:0]     quo_r;
  logic [Q_W-1:0]     qx_r;
  bpc_res_t           res_r;

  logic [LIM_W-1:0]   w_lim;
  logic [LIM_W-1:0]   h_lim;
  logic [X_POS_W-1:0] col_base;
  logic [Y_POS_W-1:0] row_base;
  logic [SUM_W-1:0]   xsum_add;
  logic [SUM_W-1:0]   ysum_add;
  logic [CNT_W-1:0]   cnt_add;
  logic               hit;
  logic               row_end;
  logic               frame_end;
  logic [CNT_W:0]     trial;
  logic               ge;
  logic [CNT_W-1:0]   rem_nxt;
  logic [Q_W-1:0]     quo_nxt;
  logic               found;

  assign w_lim = limit_size(width_r, LIM_W'(MAX_WIDTH));
  assign h_lim = limit_size(height_r, LIM_W'(MAX_HEIGHT));

  always_comb begin
    col_base = in_data.frame_start ? '0 : col_r;
    row_base = in_data.frame_start ? '0 : row_r;
    hit      = in_data.pixel_level > thr_r;
    xsum_add = (in_data.frame_start ? '0 : xsum_r) + (hit ? SUM_W'(col_base) : '0);
    ysum_add = (in_data.frame_start ? '0 : ysum_r) + (hit ? SUM_W'(row_base) : '0);
    cnt_add  = (in_data.frame_start ? '0 : cnt_r) + CNT_W'(hit);
    // A column at or past the last one ends the row, likewise for rows.
    row_end   = !((LIM_W'(col_base) + LIM_W'(1)) < w_lim);
    frame_end = row_end && !((LIM_W'(row_base) + LIM_W'(1)) < h_lim);
  end

  assign sts.frame_end = frame_end;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial   = {rem_r, quo_r[Q_W-1]};
    ge      = trial >= {1'b0, dcnt_r};
    rem_nxt = ge ? CNT_W'(trial - {1'b0, dcnt_r}) : trial[CNT_W-1:0];
    quo_nxt = Q_W'({quo_r, ge});
  end

  assign found = (dcnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THRESHOLD_RESET;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr_r    <= cfg_data[LEVEL_W-1:0];
        REG_WIDTH:     width_r  <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT:    height_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      xsum_r <= '0;
      ysum_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.accept) begin
      if (frame_end) begin
        col_r  <= '0;
        row_r  <= '0;
        xsum_r <= '0;
        ysum_r <= '0;
        cnt_r  <= '0;
      end else begin
        xsum_r <= xsum_add;
        ysum_r <= ysum_add;
        cnt_r  <= cnt_add;
        if (row_end) begin
          col_r <= '0;
          row_r <= row_base + Y_POS_W'(1);
        end else begin
          col_r <= col_base + X_POS_W'(1);
          row_r <= row_base;
        end
      end
    end
  end

  // Mean stays below 2**Q_W, so the top dividend bits start as remainder.
  always_ff @(posedge clk) begin
    if (cmd.accept && frame_end) begin
      dcnt_r <= cnt_add;
      dvy_r  <= ysum_add;
      rem_r  <= CNT_W'(xsum_add[SUM_W-1:Q_W]);
      quo_r  <= xsum_add[Q_W-1:0];
    end else if (cmd.step) begin
      if (cmd.last_x) begin
        qx_r  <= quo_nxt;
        rem_r <= CNT_W'(dvy_r[SUM_W-1:Q_W]);
        quo_r <= dvy_r[Q_W-1:0];
      end else begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_r.centroid_x <= found ? CX_W'(qx_r) : '0;
      res_r.centroid_y <= found ? CY_W'(quo_r) : '0;
      res_r.hit_count  <= HIT_W'(dcnt_r);
      res_r.found      <= found;
    end
  end

  assign out_data = res_r;

endmodule

>>> sv/bright_pixel_centroid.sv
// Top level of the thresholded bright pixel centroid block.
//
//  port group   direction  handshake            payload
//  in_*         input      in_valid / in_stall  bpc_pix_t (pixel_level, frame_start)
//  out_*        output     out_valid/out_stall  bpc_res_t (centroid, hit_count, found)
//  cfg_*        input      cfg_we               cfg_index, cfg_data
//
// One pixel per cycle while a frame streams in.
// The last pixel of a frame starts two serial divisions on one shared divider,
// then a load of the result register: in_stall stays high through both
// divisions and the load, longer while a previous result is still stalled
// on the output. Reset is synchronous; no clearing pass.
`include "bright_pixel_centroid_defines.svh"

module bright_pixel_centroid
  import bpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bpc_pix_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bpc_res_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  bpc_cmd_t cmd;
  bpc_sts_t sts;

  bpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  `BPC_ASSERT_NXT(a_stall_after_frame_end, clk, rst_n, cmd.accept && sts.frame_end, in_stall)
  `BPC_ASSERT_IMP(a_result_after_divide, clk, rst_n, $rose(out_valid), $past(in_stall))
  `BPC_ASSERT_IMP(a_empty_frame_zero, clk, rst_n, out_valid && !out_data.found, out_data.centroid_x == '0 && out_data.centroid_y == '0)
  `BPC_ASSERT_IMP(a_found_matches_count, clk, rst_n, out_valid, out_data.found == (out_data.hit_count != '0))

endmodule

>>> sim/bright_pixel_centroid_tb.sv
// Self-checking testbench for the bright_pixel_centroid block.
`timescale 1ns / 1ps

import bpc_pkg::*;

class centroid_checker;
  logic [LEVEL_W-1:0] threshold;
  logic [SIZE_W-1:0]  width_reg;
  logic [SIZE_W-1:0]  height_reg;
  logic [X_POS_W-1:0] col;
  logic [Y_POS_W-1:0] row;
  logic [29:0]        col_sum;
  logic [29:0]        row_sum;
  logic [HIT_W-1:0]   hits;
  bpc_res_t           pending_centroids[$];
  int                 mismatches;

  function new();
    threshold    = THRESHOLD_RESET;
    width_reg    = WIDTH_RESET;
    height_reg   = HEIGHT_RESET;
    mismatches   = 0;
    restart_frame();
  endfunction

  function void restart_frame();
    col     = '0;
    row     = '0;
    col_sum = '0;
    row_sum = '0;
    hits    = '0;
  endfunction

  // Zero counts as one, oversize saturates at the maximum.
  function logic [SIZE_W-1:0] fit_size(logic [SIZE_W-1:0] v, int maxv);
    if (v == '0) return SIZE_W'(1);
    if (v > maxv) return SIZE_W'(maxv);
    return v;
  endfunction

  function int frame_pixels();
    return fit_size(width_reg, MAX_WIDTH) * fit_size(height_reg, MAX_HEIGHT);
  endfunction

  function int pending();
    return pending_centroids.size();
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    case (idx)
      REG_THRESHOLD: threshold = v[LEVEL_W-1:0];
      REG_WIDTH:     width_reg = v;
      REG_HEIGHT:    height_reg = v;
      default: ;
    endcase
  endfunction

  function void take_pixel(bpc_pix_t p);
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    bpc_res_t          r;
    w = fit_size(width_reg, MAX_WIDTH);
    h = fit_size(height_reg, MAX_HEIGHT);
    // drop any partial frame
    if (p.frame_start) restart_frame();
    if (p.pixel_level > threshold) begin
      col_sum = col_sum + 30'(col);
      row_sum = row_sum + 30'(row);
      hits    = hits + 1'b1;
    end
    if (SIZE_W'(col) + SIZE_W'(1) < w) begin
      col = col + 1'b1;
      return;
    end
    col = '0;
    if (SIZE_W'(row) + SIZE_W'(1) < h) begin
      row = row + 1'b1;
      return;
    end
    r.hit_count = hits;
    r.found     = (hits != '0);
    if (r.found) begin
      r.centroid_x = CX_W'(col_sum / 30'(hits));
      r.centroid_y = CY_W'(row_sum / 30'(hits));
    end else begin
      r.centroid_x = '0;
      r.centroid_y = '0;
    end
    pending_centroids.push_back(r);
    restart_frame();
  endfunction

  function void check_result(bpc_res_t got);
    bpc_res_t want;
    if (pending_centroids.size() == 0) begin
      $error("result with no frame pending: x %0d y %0d hits %0d found %0d",
             got.centroid_x, got.centroid_y, got.hit_count, got.found);
      mismatches++;
      return;
    end
    want = pending_centroids.pop_front();
    if (got.centroid_x !== want.centroid_x) begin
      $error("centroid_x: expected %0d, actual %0d", want.centroid_x, got.centroid_x);
      mismatches++;
    end
    if (got.centroid_y !== want.centroid_y) begin
      $error("centroid_y: expected %0d, actual %0d", want.centroid_y, got.centroid_y);
      mismatches++;
    end
    if (got.hit_count !== want.hit_count) begin
      $error("hit_count: expected %0d, actual %0d", want.hit_count, got.hit_count);
      mismatches++;
    end
    if (got.found !== want.found) begin
      $error("found: expected %0d, actual %0d", want.found, got.found);
      mismatches++;
    end
  endfunction
endclass

module bright_pixel_centroid_tb;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_PIXELS = 300;
  localparam int DIRECTED_N = 27;
  localparam logic [7:0] DIRECTED_LEVELS [DIRECTED_N] = '{
    8'd0,   8'd255, 8'd251, 8'd252, 8'd128, 8'd255, 8'd0, 8'd252,
    8'd251, 8'd0,   8'd200, 8'd251, 8'd1,   8'd250, 8'd0, 8'd251,
    8'd255, 8'd255, 8'd255,
    8'd252, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0, 8'd255
  };
  // frame_start on each frame's first pixel and again after a three-pixel fragment
  localparam logic [DIRECTED_N-1:0] DIRECTED_STARTS = 27'h0090101;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  bpc_pix_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  bpc_res_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_THRESHOLD;
  logic [CFG_W-1:0]     cfg_data = '0;

  centroid_checker book;
  int gap_pct = 0;
  int stall_pct = 0;
  int pixels_sent = 0;
  int cycle_count = 0;

  bright_pixel_centroid dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bright_pixel_centroid verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Observe every transfer on all three ports.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) book.check_result(out_data);
      if (in_valid && !in_stall) book.take_pixel(in_data);
      if (cfg_we) book.set_reg(cfg_index, cfg_data);
    end
  end

  task automatic send_pixel(input logic [LEVEL_W-1:0] level, input logic start);
    bpc_pix_t pix;
    pix.pixel_level = level;
    pix.frame_start = start;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic write_reg(input bpc_reg_t idx, input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    // let the monitor record the last transfer first
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
    // hold off while the divider may still be busy
    repeat (settle) @(posedge clk);
  endtask

  // Bias levels toward the threshold edge and the range ends.
  function automatic logic [LEVEL_W-1:0] level_near(input logic [LEVEL_W-1:0] thr);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return thr;
      3: return thr + 1'b1;
      default: return LEVEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic run_phase(input logic [CFG_W-1:0] thr_word, input logic [CFG_W-1:0] w_word,
                           input logic [CFG_W-1:0] h_word, input int mode, input int budget);
    int                 sent;
    int                 n;
    int                 kind;
    int                 len;
    logic [LEVEL_W-1:0] thr;
    wait_drained(32);
    write_reg(REG_THRESHOLD, thr_word);
    write_reg(REG_WIDTH, w_word);
    write_reg(REG_HEIGHT, h_word);
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 75; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 75; end
      default: begin gap_pct = 32; stall_pct = 32; end
    endcase
    n    = book.frame_pixels();
    thr  = book.threshold;
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(0, 9);
      len  = (kind == 9) ? $urandom_range(1, n) : n;
      for (int i = 0; i < len; i++) begin
        if (kind == 9) send_pixel(level_near(thr), $urandom_range(0, 3) == 0);
        else send_pixel(level_near(thr), i == 0 && kind != 8);
      end
      sent += len;
    end
    // leave a fragment behind so the next size change lands mid-frame
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 5)) send_pixel(level_near(thr), 1'b0);
  endtask

  initial begin
    int base;
    int phase;
    book = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // threshold stays at its reset value here
    write_reg(REG_WIDTH, CFG_W'(4));
    write_reg(REG_HEIGHT, CFG_W'(2));
    for (int i = 0; i < DIRECTED_N; i++) send_pixel(DIRECTED_LEVELS[i], DIRECTED_STARTS[i]);

    // upper data bits of the threshold write are dropped, leaving zero
    run_phase(CFG_W'(11'h700), '0, '0, 0, 30);
    run_phase(CFG_W'(255), CFG_W'(5), CFG_W'(3), 1, 30);
    // oversize width saturates to a full-width single row
    run_phase(CFG_W'($urandom_range(0, 255)), '1, CFG_W'(1), 2, 1);

    base  = pixels_sent;
    phase = 0;
    while (phase < 4 || pixels_sent - base < RANDOM_PIXELS) begin
      run_phase(CFG_W'($urandom_range(0, 2047)), CFG_W'($urandom_range(0, 16)),
                CFG_W'($urandom_range(0, 8)), phase % 4, 60);
      phase++;
    end

    wait_drained(64);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("bright_pixel_centroid verification clean");
    end else begin
      $display("bright_pixel_centroid verification failed");
    end
    $finish;
  end
endmodule
